[rtl/cfb_pkg.sv]
// shared types, constants and codes for the command frame builder
`default_nettype none
package cfb_pkg;

  localparam int FRAME_BYTES    = 512;
  localparam int FRAME_OVERHEAD = 13;
  localparam int MAX_PAYLOAD    = FRAME_BYTES - FRAME_OVERHEAD;

  localparam int LEN_W   = 16;
  localparam int PLEN_W  = 9;
  localparam int CMD_W   = 32;
  localparam int BYTE_W  = 8;
  localparam int CRC_W   = 16;

  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

  // both queues
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_HIGH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_LOW   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HW_ADDRESS = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEV_KIND   = 4'd3;

  localparam logic OP_START   = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [CMD_W-1:0]  command;
    logic [PLEN_W-1:0] payload_len;
    logic [BYTE_W-1:0] data;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] tx_byte;
    logic              frame_end;
    logic              unexpected;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] head_high;
    logic [BYTE_W-1:0] head_low;
    logic [BYTE_W-1:0] hw_address;
    logic [CRC_W-1:0]  dev_kind;
  } cfg_t;

  typedef enum logic [1:0] {
    KIND_START   = 2'b00,
    KIND_PAYLOAD = 2'b01,
    KIND_UNEXP   = 2'b10
  } cmd_kind_t;

  // classified request handed from front to back
  typedef struct packed {
    cmd_kind_t         kind;
    logic              crc_after;
    logic [CMD_W-1:0]  command;
    logic [PLEN_W-1:0] plen;
    logic [BYTE_W-1:0] data;
  } cmd_t;

endpackage
`default_nettype wire

[rtl/cfb_front.sv]
// front end: tracks the open frame and classifies each incoming request
`default_nettype none
module cfb_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire cfb_pkg::in_item_t item,
  output cfb_pkg::cmd_t          cmd
);

  logic                       open_r, open_nxt;
  logic [cfb_pkg::PLEN_W-1:0] left_r, left_nxt;
  logic [cfb_pkg::PLEN_W-1:0] plen_c;
  logic [cfb_pkg::PLEN_W-1:0] left_dec;

  // clamp so the whole frame stays within FRAME_BYTES
  always_comb begin
    if (cfb_pkg::LEN_W'(item.payload_len) > cfb_pkg::LEN_W'(cfb_pkg::MAX_PAYLOAD)) begin
      plen_c = cfb_pkg::PLEN_W'(cfb_pkg::MAX_PAYLOAD);
    end else begin
      plen_c = item.payload_len;
    end
  end

  assign left_dec = left_r - cfb_pkg::PLEN_W'(1);

  always_comb begin
    open_nxt      = open_r;
    left_nxt      = left_r;
    cmd.command   = item.command;
    cmd.plen      = plen_c;
    cmd.data      = item.data;
    cmd.kind      = cfb_pkg::KIND_UNEXP;
    cmd.crc_after = 1'b0;
    if (item.opcode == cfb_pkg::OP_START) begin
      cmd.kind      = cfb_pkg::KIND_START;
      cmd.crc_after = (plen_c == '0);
      open_nxt      = (plen_c != '0);
      left_nxt      = plen_c;
    end else if (open_r) begin
      cmd.kind      = cfb_pkg::KIND_PAYLOAD;
      cmd.crc_after = (left_dec == '0);
      open_nxt      = (left_dec != '0);
      left_nxt      = left_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      left_r <= '0;
    end else if (accept) begin
      open_r <= open_nxt;
      left_r <= left_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/cfb_cmdq.sv]
// short queue of classified requests between front and back
`default_nettype none
module cfb_cmdq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr,
  input  wire cfb_pkg::cmd_t wdata,
  input  wire logic          rd,
  output cfb_pkg::cmd_t      rdata,
  output logic               full,
  output logic               empty
);

  cfb_pkg::cmd_t              mem [cfb_pkg::QDEPTH];
  logic [cfb_pkg::QPTR_W-1:0] wp_r, rp_r;
  logic [cfb_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic                       do_wr, do_rd;

  assign full  = (cnt_r == cfb_pkg::QCNT_W'(cfb_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + cfb_pkg::QCNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - cfb_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= wp_r + cfb_pkg::QPTR_W'(1);
      if (do_rd) rp_r <= rp_r + cfb_pkg::QPTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/cfb_outq.sv]
// result queue that parts the byte sequencer from the consumer
`default_nettype none
module cfb_outq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr,
  input  wire cfb_pkg::out_item_t wdata,
  input  wire logic              rd,
  output cfb_pkg::out_item_t     rdata,
  output logic                   full,
  output logic                   empty
);

  cfb_pkg::out_item_t         mem [cfb_pkg::QDEPTH];
  logic [cfb_pkg::QPTR_W-1:0] wp_r, rp_r;
  logic [cfb_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic                       do_wr, do_rd;

  assign full  = (cnt_r == cfb_pkg::QCNT_W'(cfb_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + cfb_pkg::QCNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - cfb_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= wp_r + cfb_pkg::QPTR_W'(1);
      if (do_rd) rp_r <= rp_r + cfb_pkg::QPTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/cfb_back.sv]
// back end: walks each request byte by byte and keeps the running crc
`default_nettype none
module cfb_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cfb_pkg::cfg_t cfg,
  input  wire cfb_pkg::cmd_t cmd,
  input  wire logic          cmd_empty,
  output logic               cmd_pop,
  input  wire logic          oq_full,
  output logic               oq_push,
  output cfb_pkg::out_item_t oq_item
);

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] OFF_HEAD_HIGH = 4'd0;
  localparam logic [STEP_W-1:0] OFF_HEAD_LOW  = 4'd1;
  localparam logic [STEP_W-1:0] OFF_LEN_HI    = 4'd2;
  localparam logic [STEP_W-1:0] OFF_LEN_LO    = 4'd3;
  localparam logic [STEP_W-1:0] OFF_HW_ADDR   = 4'd4;
  localparam logic [STEP_W-1:0] OFF_BOARD_HI  = 4'd5;
  localparam logic [STEP_W-1:0] OFF_BOARD_LO  = 4'd6;
  localparam logic [STEP_W-1:0] OFF_CMD_3     = 4'd7;
  localparam logic [STEP_W-1:0] OFF_CMD_2     = 4'd8;
  localparam logic [STEP_W-1:0] OFF_CMD_1     = 4'd9;
  localparam logic [STEP_W-1:0] OFF_CMD_0     = 4'd10;
  localparam logic [STEP_W-1:0] OFF_CRC_HI    = 4'd11;
  localparam logic [STEP_W-1:0] OFF_CRC_LO    = 4'd12;
  localparam logic [STEP_W-1:0] PL_CRC_HI     = 4'd1;
  localparam logic [STEP_W-1:0] PL_CRC_LO     = 4'd2;

  function automatic logic [cfb_pkg::CRC_W-1:0] crc_fold(
    input logic [cfb_pkg::CRC_W-1:0]  crc_in,
    input logic [cfb_pkg::BYTE_W-1:0] b
  );
    logic [cfb_pkg::CRC_W-1:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ cfb_pkg::CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  logic [STEP_W-1:0]          step_r, step_nxt;
  logic [cfb_pkg::CRC_W-1:0]  crc_r, crc_nxt, crc_base;
  logic [cfb_pkg::LEN_W-1:0]  total;
  logic [cfb_pkg::BYTE_W-1:0] hdr_byte, tx;
  logic                       emit, is_last, is_crc_hi, is_crc_lo;

  assign emit  = !cmd_empty && !oq_full;
  assign total = cfb_pkg::LEN_W'(cmd.plen) + cfb_pkg::LEN_W'(cfb_pkg::FRAME_OVERHEAD);

  always_comb begin
    unique case (step_r)
      OFF_HEAD_HIGH: hdr_byte = cfg.head_high;
      OFF_HEAD_LOW:  hdr_byte = cfg.head_low;
      OFF_LEN_HI:    hdr_byte = total[15:8];
      OFF_LEN_LO:    hdr_byte = total[7:0];
      OFF_HW_ADDR:   hdr_byte = cfg.hw_address;
      OFF_BOARD_HI:  hdr_byte = cfg.dev_kind[15:8];
      OFF_BOARD_LO:  hdr_byte = cfg.dev_kind[7:0];
      OFF_CMD_3:     hdr_byte = cmd.command[31:24];
      OFF_CMD_2:     hdr_byte = cmd.command[23:16];
      OFF_CMD_1:     hdr_byte = cmd.command[15:8];
      OFF_CMD_0:     hdr_byte = cmd.command[7:0];
      default:       hdr_byte = '0;
    endcase
  end

  always_comb begin
    is_crc_hi = 1'b0;
    is_crc_lo = 1'b0;
    is_last   = 1'b1;
    tx        = '0;
    unique case (cmd.kind)
      cfb_pkg::KIND_START: begin
        is_crc_hi = (step_r == OFF_CRC_HI);
        is_crc_lo = (step_r == OFF_CRC_LO);
        is_last   = cmd.crc_after ? (step_r == OFF_CRC_LO) : (step_r == OFF_CMD_0);
        tx        = hdr_byte;
      end
      cfb_pkg::KIND_PAYLOAD: begin
        is_crc_hi = (step_r == PL_CRC_HI);
        is_crc_lo = (step_r == PL_CRC_LO);
        is_last   = cmd.crc_after ? (step_r == PL_CRC_LO) : 1'b1;
        tx        = cmd.data;
      end
      default: begin
        is_last = 1'b1;
        tx      = '0;
      end
    endcase
    if (is_crc_hi) tx = crc_r[15:8];
    if (is_crc_lo) tx = crc_r[7:0];
  end

  // a start always folds from a fresh crc, abandoning any open frame
  assign crc_base = (cmd.kind == cfb_pkg::KIND_START && step_r == OFF_HEAD_HIGH) ?
                    cfb_pkg::CRC_INIT : crc_r;

  always_comb begin
    crc_nxt = crc_r;
    if (is_crc_lo) begin
      crc_nxt = cfb_pkg::CRC_INIT;
    end else if (!is_crc_hi && cmd.kind != cfb_pkg::KIND_UNEXP) begin
      crc_nxt = crc_fold(crc_base, tx);
    end
    step_nxt = is_last ? '0 : step_r + STEP_W'(1);
  end

  assign cmd_pop            = emit && is_last;
  assign oq_push            = emit;
  assign oq_item.tx_byte    = tx;
  assign oq_item.frame_end  = is_crc_lo;
  assign oq_item.unexpected = (cmd.kind == cfb_pkg::KIND_UNEXP);
  assign oq_item.last       = is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      crc_r  <= cfb_pkg::CRC_INIT;
    end else if (emit) begin
      step_r <= step_nxt;
      crc_r  <= crc_nxt;
    end
  end

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    oq_push && oq_item.frame_end |-> oq_item.last)
    else $error("frame end not on the last byte of its request");

  a_crc_reinit: assert property (@(posedge clk) disable iff (!rst_n)
    oq_push && oq_item.frame_end |=> crc_r == cfb_pkg::CRC_INIT)
    else $error("crc not reinitialised after frame end");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= OFF_CRC_LO)
    else $error("byte step out of range");

  a_step_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd_empty && oq_full |=> $stable(step_r))
    else $error("byte step moved while result queue full");

endmodule
`default_nettype wire

[rtl/crc16_command_frame_builder_core.sv]
// top level: config registers, front end, request queue, byte sequencer, result queue
//
//  channel  ports                          handshake
//  input    push, full, in_item            taken when push && !full
//  result   empty, pop, out_item           taken when pop && !empty
//  config   cfg_we, cfg_idx, cfg_wdata     written when cfg_we
//
// a request enters each cycle while the 4-deep request queue has room
// the sequencer sends one byte a cycle when not stalled by the queues: payload 1 byte,
// 3 when it closes the frame, start 11 bytes, 13 with an empty payload
// throughput is set by the single byte-per-cycle sequencer and crc fold
// rst_n is synchronous and resets queues, frame state, crc and config registers
// either side may stall on its own; both 4-deep queues absorb the difference
`default_nettype none
module crc16_command_frame_builder_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               push,
  output logic                                    full,
  input  wire cfb_pkg::in_item_t                  in_item,
  output logic                                    empty,
  input  wire logic                               pop,
  output cfb_pkg::out_item_t                      out_item,
  input  wire logic                               cfg_we,
  input  wire logic [cfb_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  wire logic [cfb_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  cfb_pkg::cfg_t      cfg_r;
  cfb_pkg::cmd_t      front_cmd, back_cmd;
  cfb_pkg::out_item_t oq_item;
  logic               accept, cmd_empty, cmd_pop, oq_full, oq_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        cfb_pkg::REG_HEAD_HIGH:  cfg_r.head_high  <= cfg_wdata[7:0];
        cfb_pkg::REG_HEAD_LOW:   cfg_r.head_low   <= cfg_wdata[7:0];
        cfb_pkg::REG_HW_ADDRESS: cfg_r.hw_address <= cfg_wdata[7:0];
        cfb_pkg::REG_DEV_KIND:   cfg_r.dev_kind   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign accept = push && !full;

  cfb_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_item),
    .cmd    (front_cmd)
  );

  cfb_cmdq u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (accept),
    .wdata (front_cmd),
    .rd    (cmd_pop),
    .rdata (back_cmd),
    .full  (full),
    .empty (cmd_empty)
  );

  cfb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd       (back_cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .oq_full   (oq_full),
    .oq_push   (oq_push),
    .oq_item   (oq_item)
  );

  cfb_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (oq_push),
    .wdata (oq_item),
    .rd    (pop),
    .rdata (out_item),
    .full  (oq_full),
    .empty (empty)
  );

endmodule
`default_nettype wire
